// File: hdl/header_length_trailer_deframer_top_defines.svh
// ----------------------------------------------------------------------------
// Header, length and trailer deframer: assertion macros
// Shared concurrent assertion macros for the deframer modules.
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_TRAILER_DEFRAMER_TOP_DEFINES_SVH
`define HEADER_LENGTH_TRAILER_DEFRAMER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLTD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HLTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// File: hdl/hltd_pkg.sv
// ----------------------------------------------------------------------------
// Header, length and trailer deframer: package
// Types, register map and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hltd_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 1024;
  localparam int FIFO_DEPTH = 4;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_FRAME_MODE     = 3'd0,
    REG_HEADER_FIRST   = 3'd1,
    REG_HEADER_SECOND  = 3'd2,
    REG_TRAILER_FIRST  = 3'd3,
    REG_TRAILER_SECOND = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_LEN    = 2'd1,
    PH_LEN_HI = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IN   = 2'd0,
    ST_GOOD = 2'd1,
    ST_BAD  = 2'd2,
    ST_LONG = 2'd3
  } status_t;

  typedef struct packed {
    logic       frame_mode;
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] trailer_first;
    logic [7:0] trailer_second;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    frame_mode:     1'b1,
    header_first:   8'd170,
    header_second:  8'd85,
    trailer_first:  8'd85,
    trailer_second: 8'd170
  };

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_last;
    status_t    frame_status;
  } result_t;

  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// File: hdl/hltd_if.sv
// ----------------------------------------------------------------------------
// Header, length and trailer deframer: stream interfaces
// Valid/ready channels for received bytes and for deframed result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface hltd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hltd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_last;
  logic [1:0] frame_status;

  modport source (output valid, output out_byte, output frame_last, output frame_status,
                  input ready);
  modport sink (input valid, input out_byte, input frame_last, input frame_status,
                output ready);
endinterface

`default_nettype wire

// File: hdl/hltd_regs.sv
// ----------------------------------------------------------------------------
// Header, length and trailer deframer: configuration registers
// APB-style register file holding the mode and the header and trailer bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module hltd_regs
  import hltd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg,
  output logic                    restart
);

  reg_index_t index;
  logic       wr_en;

  assign index   = reg_index_t'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign restart = wr_en && (index == REG_FRAME_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (index)
        REG_FRAME_MODE:     cfg.frame_mode     <= pwdata[0];
        REG_HEADER_FIRST:   cfg.header_first   <= pwdata[7:0];
        REG_HEADER_SECOND:  cfg.header_second  <= pwdata[7:0];
        REG_TRAILER_FIRST:  cfg.trailer_first  <= pwdata[7:0];
        REG_TRAILER_SECOND: cfg.trailer_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (index)
      REG_FRAME_MODE:     prdata[0]   = cfg.frame_mode;
      REG_HEADER_FIRST:   prdata[7:0] = cfg.header_first;
      REG_HEADER_SECOND:  prdata[7:0] = cfg.header_second;
      REG_TRAILER_FIRST:  prdata[7:0] = cfg.trailer_first;
      REG_TRAILER_SECOND: prdata[7:0] = cfg.trailer_second;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/hltd_core.sv
// ----------------------------------------------------------------------------
// Header, length and trailer deframer: framing state machine
// Tracks hunt, length and body phases and produces up to two beats per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hltd_core
  import hltd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       restart,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output push_t           push
);

  `include "header_length_trailer_deframer_top_defines.svh"

  localparam int LW = $clog2(MAX_PAYLOAD + 1);
  localparam int OW = $clog2(MAX_PAYLOAD + 6);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  phase_t          phase, phase_next;
  logic [OW-1:0]   byte_offset, byte_offset_next;
  logic [LW-1:0]   payload_length, payload_length_next;
  logic            held_header_flag, held_header_flag_next;
  logic            trailer_first_matched, trailer_first_matched_next;

  logic [15:0]     len_full;
  logic [OW-1:0]   trailer_pos;
  logic            at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                 <= PH_HUNT;
      byte_offset           <= '0;
      payload_length        <= '0;
      held_header_flag      <= 1'b0;
      trailer_first_matched <= 1'b0;
    end else begin
      phase                 <= phase_next;
      byte_offset           <= byte_offset_next;
      payload_length        <= payload_length_next;
      held_header_flag      <= held_header_flag_next;
      trailer_first_matched <= trailer_first_matched_next;
    end
  end

  always_comb begin
    phase_next                 = phase;
    byte_offset_next           = byte_offset;
    payload_length_next        = payload_length;
    held_header_flag_next      = held_header_flag;
    trailer_first_matched_next = trailer_first_matched;
    push                       = '0;
    push.r0.out_byte           = rx_byte;
    push.r1.out_byte           = rx_byte;
    len_full                   = 16'({8'd0, rx_byte});
    trailer_pos                = OW'(payload_length) + OW'(2);
    at_last                    = 1'b0;

    if (restart) begin
      phase_next                 = PH_HUNT;
      byte_offset_next           = '0;
      payload_length_next        = '0;
      held_header_flag_next      = 1'b0;
      trailer_first_matched_next = 1'b0;
    end else if (accept) begin
      unique case (phase)
        PH_HUNT: begin
          if (!cfg.frame_mode) begin
            if (rx_byte == cfg.header_first) begin
              phase_next       = PH_LEN;
              byte_offset_next = OW'(1);
              push.num         = 2'd1;
            end
          end else if (held_header_flag && (rx_byte == cfg.header_second)) begin
            held_header_flag_next = 1'b0;
            phase_next            = PH_LEN;
            byte_offset_next      = OW'(2);
            push.num              = 2'd2;
            push.r0.out_byte      = cfg.header_first;
          end else begin
            held_header_flag_next = (rx_byte == cfg.header_first);
          end
        end
        PH_LEN: begin
          push.num = 2'd1;
          if (!cfg.frame_mode) begin
            if (len_full > MAX_LEN) begin
              phase_next              = PH_HUNT;
              byte_offset_next        = '0;
              payload_length_next     = '0;
              push.r0.frame_last      = 1'b1;
              push.r0.frame_status    = ST_LONG;
            end else begin
              phase_next                 = PH_BODY;
              byte_offset_next           = OW'(2);
              payload_length_next        = LW'(len_full);
              trailer_first_matched_next = 1'b0;
            end
          end else begin
            payload_length_next[7:0] = rx_byte;
            phase_next               = PH_LEN_HI;
            byte_offset_next         = OW'(3);
          end
        end
        PH_LEN_HI: begin
          push.num = 2'd1;
          len_full = {rx_byte, payload_length[7:0]};
          if (len_full > MAX_LEN) begin
            phase_next           = PH_HUNT;
            byte_offset_next     = '0;
            payload_length_next  = '0;
            push.r0.frame_last   = 1'b1;
            push.r0.frame_status = ST_LONG;
          end else begin
            phase_next                 = PH_BODY;
            byte_offset_next           = OW'(4);
            payload_length_next        = LW'(len_full);
            trailer_first_matched_next = 1'b0;
          end
        end
        PH_BODY: begin
          push.num = 2'd1;
          if (!cfg.frame_mode) begin
            at_last = (byte_offset == trailer_pos);
            if (at_last) begin
              push.r0.frame_status = (rx_byte == cfg.trailer_first) ? ST_GOOD : ST_BAD;
            end
          end else begin
            trailer_pos = OW'(payload_length) + OW'(4);
            at_last     = (byte_offset == trailer_pos + OW'(1));
            if (byte_offset == trailer_pos) begin
              trailer_first_matched_next = (rx_byte == cfg.trailer_first);
            end
            if (at_last) begin
              push.r0.frame_status =
                (trailer_first_matched && (rx_byte == cfg.trailer_second)) ? ST_GOOD : ST_BAD;
            end
          end
          if (at_last) begin
            phase_next                 = PH_HUNT;
            byte_offset_next           = '0;
            payload_length_next        = '0;
            trailer_first_matched_next = 1'b0;
            push.r0.frame_last         = 1'b1;
          end else begin
            byte_offset_next = byte_offset + OW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  `HLTD_ASSERT_SAME(a_len_bounded, clk, rst, phase == PH_BODY,
                    payload_length <= LW'(MAX_PAYLOAD))
  `HLTD_ASSERT_SAME(a_held_only_hunting, clk, rst, held_header_flag,
                    phase == PH_HUNT && cfg.frame_mode)
  `HLTD_ASSERT_SAME(a_two_beats_header, clk, rst, push.num == 2'd2,
                    phase == PH_HUNT && push.r0.out_byte == cfg.header_first)
  `HLTD_ASSERT_SAME(a_offset_in_frame, clk, rst, phase == PH_BODY,
                    byte_offset <= OW'(payload_length) + OW'(5))

endmodule

`default_nettype wire

// File: hdl/hltd_out_fifo.sv
// ----------------------------------------------------------------------------
// Header, length and trailer deframer: result queue
// Small register queue taking up to two beats per cycle and giving one.
// ----------------------------------------------------------------------------
`default_nettype none

module hltd_out_fifo
  import hltd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_data
);

  `include "header_length_trailer_deframer_top_defines.svh"

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t             entries [FIFO_DEPTH];
  logic [PTR_W-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0]    count, count_next;
  logic                pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign in_ready  = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign count_next = count + CNT_W'(push.num) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.num == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.r1;
    end
  end

  `HLTD_ASSERT_SAME(a_count_bounded, clk, rst, 1'b1, count <= CNT_W'(FIFO_DEPTH))
  `HLTD_ASSERT_SAME(a_no_overflow, clk, rst, push.num != 2'd0,
                    count + CNT_W'(push.num) <= CNT_W'(FIFO_DEPTH))
  `HLTD_ASSERT_NEXT(a_push_shows, clk, rst, push.num != 2'd0, out_valid)

endmodule

`default_nettype wire

// File: hdl/header_length_trailer_deframer_top.sv
// ----------------------------------------------------------------------------
// Header, length and trailer deframer: top level
// Path: an accepted frame byte is written into the result queue and offered on res from there.
// Throughput: one received byte per cycle; rx.ready drops while three or more of the
// four result queue entries are held, so a two-beat mode 1 header always has room.
// Reset: synchronous rst returns the registers to their defaults, empties the
// queue and puts the framer back to hunting; a frame_mode write also restarts the hunt.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_trailer_deframer_top
  import hltd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  hltd_rx_if.sink                 rx,
  hltd_res_if.source              res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  cfg_t    cfg;
  logic    restart;
  logic    accept;
  logic    in_ready;
  push_t   push;
  result_t out_data;

  assign rx.ready = in_ready;
  assign accept   = rx.valid && in_ready;

  hltd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  hltd_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .push    (push)
  );

  hltd_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_ready  (in_ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_data)
  );

  assign res.out_byte     = out_data.out_byte;
  assign res.frame_last   = out_data.frame_last;
  assign res.frame_status = out_data.frame_status;

endmodule

`default_nettype wire

// File: verif/header_length_trailer_deframer_top_test.sv
// ----------------------------------------------------------------------------
// Header, length and trailer deframer: self-checking testbench
// Feeds received bytes through a valid/ready channel and checks every result
// beat against an in-bench model of the framer. The run opens with a table of
// directed bytes and register writes, then goes through eight register
// settings with random frames, noise and truncated frames, random idling on
// both channels, and one long hold-off on the result side.
// ----------------------------------------------------------------------------

module header_length_trailer_deframer_top_test;
  import hltd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN = MAX_PAYLOAD_DEFAULT;
  localparam int PHASE_ITEMS = 150;

  typedef struct packed {
    logic       is_cfg;
    reg_index_t idx;
    logic [7:0] val;
    logic       typed;
    result_t    want;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  hltd_rx_if  rx_ch ();
  hltd_res_if res_ch ();

  header_length_trailer_deframer_top #(
    .MAX_PAYLOAD(MAX_LEN)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .res    (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Framer model state and register copy.
  cfg_t        pred_cfg;
  phase_t      pred_phase;
  logic [16:0] pred_offset;
  logic [15:0] pred_len;
  logic        pred_held;
  logic        pred_trl1_ok;

  result_t expected_beats[$];
  int      mismatches = 0;
  int      items_sent = 0;
  int      beats_seen = 0;
  int      frames_good = 0;
  int      frames_bad = 0;
  int      frames_long = 0;
  bit      steady = 1'b0;
  bit      hold_req = 1'b0;
  bit      big_frame_due = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic result_t mk_beat(input logic [7:0] b, input logic last,
                                      input status_t st);
    result_t r;
    r.out_byte = b;
    r.frame_last = last;
    r.frame_status = st;
    return r;
  endfunction

  function automatic void restart_hunt();
    pred_phase = PH_HUNT;
    pred_offset = '0;
    pred_len = '0;
    pred_held = 1'b0;
    pred_trl1_ok = 1'b0;
  endfunction

  // Returns how many beats the byte releases; they come back in r0 and r1.
  function automatic int deframe_predict(input logic [7:0] b, output result_t r0,
                                         output result_t r1);
    logic [16:0] tpos;
    status_t     st;
    r0 = '0;
    r1 = '0;
    case (pred_phase)
      PH_HUNT: begin
        if (!pred_cfg.frame_mode) begin
          if (b == pred_cfg.header_first) begin
            pred_phase = PH_LEN;
            pred_offset = 17'd1;
            r0 = mk_beat(b, 1'b0, ST_IN);
            return 1;
          end
          return 0;
        end
        if (pred_held && b == pred_cfg.header_second) begin
          pred_held = 1'b0;
          pred_phase = PH_LEN;
          pred_offset = 17'd2;
          r0 = mk_beat(pred_cfg.header_first, 1'b0, ST_IN);
          r1 = mk_beat(b, 1'b0, ST_IN);
          return 2;
        end
        pred_held = (b == pred_cfg.header_first);
        return 0;
      end
      PH_LEN: begin
        pred_len = {8'd0, b};
        if (pred_cfg.frame_mode) begin
          pred_phase = PH_LEN_HI;
          pred_offset = 17'd3;
          r0 = mk_beat(b, 1'b0, ST_IN);
          return 1;
        end
        if (int'(pred_len) > MAX_LEN) begin
          restart_hunt();
          r0 = mk_beat(b, 1'b1, ST_LONG);
          return 1;
        end
        pred_phase = PH_BODY;
        pred_offset = 17'd2;
        pred_trl1_ok = 1'b0;
        r0 = mk_beat(b, 1'b0, ST_IN);
        return 1;
      end
      PH_LEN_HI: begin
        pred_len = {b, pred_len[7:0]};
        if (int'(pred_len) > MAX_LEN) begin
          restart_hunt();
          r0 = mk_beat(b, 1'b1, ST_LONG);
          return 1;
        end
        pred_phase = PH_BODY;
        pred_offset = 17'd4;
        pred_trl1_ok = 1'b0;
        r0 = mk_beat(b, 1'b0, ST_IN);
        return 1;
      end
      default: begin
      end
    endcase
    if (!pred_cfg.frame_mode) begin
      tpos = 17'(pred_len) + 17'd2;
      if (pred_offset >= tpos) begin
        st = (b == pred_cfg.trailer_first) ? ST_GOOD : ST_BAD;
        restart_hunt();
        r0 = mk_beat(b, 1'b1, st);
        return 1;
      end
    end else begin
      tpos = 17'(pred_len) + 17'd4;
      if (pred_offset == tpos) begin
        pred_trl1_ok = (b == pred_cfg.trailer_first);
      end else if (pred_offset > tpos) begin
        st = (pred_trl1_ok && b == pred_cfg.trailer_second) ? ST_GOOD : ST_BAD;
        restart_hunt();
        r0 = mk_beat(b, 1'b1, st);
        return 1;
      end
    end
    pred_offset = pred_offset + 17'd1;
    r0 = mk_beat(b, 1'b0, ST_IN);
    return 1;
  endfunction

  function automatic dir_row_t rx_row(input logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.val = b;
    return r;
  endfunction

  function automatic dir_row_t rx_chk(input logic [7:0] b, input logic last,
                                      input status_t st);
    dir_row_t r;
    r = rx_row(b);
    r.typed = 1'b1;
    r.want = mk_beat(b, last, st);
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input reg_index_t idx, input logic [7:0] v);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = v;
    return r;
  endfunction

  task automatic send_rx(input logic [7:0] b, input logic typed, input result_t want);
    result_t p0;
    result_t p1;
    int      n;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 25) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    items_sent++;
    n = deframe_predict(b, p0, p1);
    if (typed) begin
      expected_beats.push_back(want);
    end else begin
      if (n > 0) expected_beats.push_back(p0);
      if (n > 1) expected_beats.push_back(p1);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [7:0] v);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2;
    pwdata <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_FRAME_MODE: begin
        pred_cfg.frame_mode = v[0];
        restart_hunt();
      end
      REG_HEADER_FIRST: pred_cfg.header_first = v;
      REG_HEADER_SECOND: pred_cfg.header_second = v;
      REG_TRAILER_FIRST: pred_cfg.trailer_first = v;
      REG_TRAILER_SECOND: pred_cfg.trailer_second = v;
      default: begin
      end
    endcase
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(v)) begin
      $error("prdata of register %s: expected %0h, got %0h", idx.name(), v, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_frame();
    logic [7:0]  fb[$];
    logic [15:0] plen;
    int          roll;
    int          len;
    int          cut;
    roll = $urandom_range(99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 6)) send_rx(8'($urandom), 1'b0, '0);
      return;
    end
    fb.push_back(pred_cfg.header_first);
    if (pred_cfg.frame_mode) fb.push_back(pred_cfg.header_second);
    if (big_frame_due) begin
      len = pred_cfg.frame_mode ? MAX_LEN : 255;
      big_frame_due = 1'b0;
    end else if (pred_cfg.frame_mode && roll < 18) begin
      len = $urandom_range(MAX_LEN + 1, 65535);
    end else if (roll < 28) begin
      len = $urandom_range(13, 64);
    end else begin
      len = $urandom_range(0, 12);
    end
    plen = 16'(len);
    fb.push_back(plen[7:0]);
    if (pred_cfg.frame_mode) fb.push_back(plen[15:8]);
    if (len <= MAX_LEN) begin
      repeat (len) begin
        fb.push_back(($urandom_range(9) == 0) ? pred_cfg.header_first : 8'($urandom));
      end
      if ($urandom_range(4) != 0) begin
        fb.push_back(pred_cfg.trailer_first);
        if (pred_cfg.frame_mode) fb.push_back(pred_cfg.trailer_second);
      end else begin
        fb.push_back(($urandom_range(1) == 0) ? pred_cfg.trailer_first : 8'($urandom));
        if (pred_cfg.frame_mode) fb.push_back(8'($urandom));
      end
    end
    // A truncated frame lets the next bytes land in the body of this one.
    if ($urandom_range(99) < 8) begin
      cut = $urandom_range(1, fb.size());
      while (fb.size() > cut) void'(fb.pop_back());
    end
    foreach (fb[i]) send_rx(fb[i], 1'b0, '0);
  endtask

  always @(posedge clk) begin : check_beats
    result_t exp;
    if (!rst && res_ch.valid && res_ch.ready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $error("result beat %02h arrived with no expectation pending", res_ch.out_byte);
        mismatches++;
      end else begin
        exp = expected_beats.pop_front();
        if (res_ch.out_byte !== exp.out_byte) begin
          $error("out_byte: expected %02h, got %02h", exp.out_byte, res_ch.out_byte);
          mismatches++;
        end
        if (res_ch.frame_last !== exp.frame_last) begin
          $error("frame_last: expected %0d, got %0d", exp.frame_last, res_ch.frame_last);
          mismatches++;
        end
        if (res_ch.frame_status !== exp.frame_status) begin
          $error("frame_status: expected %0d, got %0d", exp.frame_status,
                 res_ch.frame_status);
          mismatches++;
        end
      end
      if (res_ch.frame_last === 1'b1) begin
        case (status_t'(res_ch.frame_status))
          ST_GOOD: frames_good++;
          ST_BAD: frames_bad++;
          ST_LONG: frames_long++;
          default: begin
          end
        endcase
      end
    end
  end

  initial begin : result_side
    int hold_left;
    hold_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 300;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (steady) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= 25);
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows[28];
    cfg_t     s;
    int       start;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pred_cfg = CFG_RESET;
    restart_hunt();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    dir_rows = '{
      rx_row(8'h00), rx_row(8'hAA), rx_row(8'hAA), rx_row(8'h55),
      rx_chk(8'h00, 1'b0, ST_IN), rx_chk(8'h00, 1'b0, ST_IN),
      rx_chk(8'h55, 1'b0, ST_IN), rx_chk(8'hAA, 1'b1, ST_GOOD),
      rx_row(8'hAA), rx_row(8'h55),
      rx_chk(8'h01, 1'b0, ST_IN), rx_chk(8'h04, 1'b1, ST_LONG),
      rx_row(8'hAA), rx_row(8'h55),
      rx_chk(8'h00, 1'b0, ST_IN), rx_chk(8'h00, 1'b0, ST_IN),
      rx_chk(8'hAA, 1'b0, ST_IN), rx_chk(8'hAA, 1'b1, ST_BAD),
      rx_row(8'hAA), cfg_row(REG_FRAME_MODE, 8'd1), rx_row(8'h55),
      cfg_row(REG_FRAME_MODE, 8'd0),
      rx_chk(8'hAA, 1'b0, ST_IN), rx_chk(8'h00, 1'b0, ST_IN),
      rx_chk(8'h55, 1'b1, ST_GOOD),
      rx_chk(8'hAA, 1'b0, ST_IN), rx_chk(8'h00, 1'b0, ST_IN),
      rx_chk(8'hFF, 1'b1, ST_BAD)
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) cfg_write(dir_rows[i].idx, dir_rows[i].val);
      else send_rx(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: s = '{1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00};
        1: s = '{1'b1, 8'h00, 8'hFF, 8'hFF, 8'h00};
        2: s = '{1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF};
        3: s = '{1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF};
        7: s = CFG_RESET;
        default: s = '{ph[0] ? 1'b0 : 1'b1, 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom)};
      endcase
      cfg_write(REG_FRAME_MODE, {7'd0, s.frame_mode});
      cfg_write(REG_HEADER_FIRST, s.header_first);
      cfg_write(REG_HEADER_SECOND, s.header_second);
      cfg_write(REG_TRAILER_FIRST, s.trailer_first);
      cfg_write(REG_TRAILER_SECOND, s.trailer_second);
      steady = (ph == 3);
      big_frame_due = (ph <= 1);
      if (ph == 4) hold_req = 1'b1;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_frame();
    end

    steady = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $error("%0d expected beats never arrived", expected_beats.size());
      mismatches++;
    end
    $display("Run: %0d received bytes over 8 register settings, %0d result beats.",
             items_sent, beats_seen);
    $display("Frames closed: %0d good trailer, %0d bad trailer, %0d length too long.",
             frames_good, frames_bad, frames_long);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
